### src/assert_macros.svh
// Assertion macros for the checker file of this block.
// Every macro samples on the rising edge of clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst_ni is high.
`define ORS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define ORS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/orsrch_pkg.sv
`default_nettype none

package orsrch_pkg;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    KIND_RESTART = 2'd0,
    KIND_PASS    = 2'd1,
    KIND_PAIR    = 2'd2
  } kind_e;

  localparam int unsigned ROM_W      = 64;
  localparam int unsigned POS_W      = 7;
  localparam int unsigned FAM_W      = 4;
  localparam int unsigned CRC_BYTES  = 7;
  localparam int unsigned CRC_BITS   = CRC_BYTES * 8;
  localparam logic [7:0]  CRC_POLY   = 8'h8C;

  localparam logic [POS_W-1:0] END_POSITION = POS_W'(65);
  localparam logic [POS_W-1:0] FAMILY_LIMIT = POS_W'(9);

  // Field layout of the output tdata, lowest bit first.
  localparam int unsigned OUT_SEND_BIT    = 0;
  localparam int unsigned OUT_WVALID_BIT  = 1;
  localparam int unsigned OUT_DIR_BIT     = 2;
  localparam int unsigned OUT_FOUND_BIT   = 3;
  localparam int unsigned OUT_LASTDEV_BIT = 4;
  localparam int unsigned OUT_FIELDS_W    = 5 + ROM_W + 1 + FAM_W;
  localparam int unsigned OUT_DATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef struct packed {
    logic [ROM_W-1:0] rom;
    logic [7:0]       crc;        // CRC-8 of the low seven bytes of rom
    logic [POS_W-1:0] last_disc;
    logic [FAM_W-1:0] last_fam;
    logic             last_dev;
    logic             in_pass;
    logic [POS_W-1:0] bit_pos;
    logic [POS_W-1:0] zero_pos;
  } state_t;

  localparam state_t STATE_RESET = '{
    rom:       '0,
    crc:       '0,
    last_disc: '0,
    last_fam:  '0,
    last_dev:  1'b0,
    in_pass:   1'b0,
    bit_pos:   POS_W'(1),
    zero_pos:  '0
  };

  typedef struct packed {
    logic [1:0] kind;
    logic       presence;
    logic       id_bit;
    logic       complement_bit;
  } item_t;

  typedef struct packed {
    logic             send_search_command;
    logic             write_valid;
    logic             direction_bit;
    logic             pass_done;
    logic             device_found;
    logic             last_device;
    logic [ROM_W-1:0] rom_code;
    logic             crc_ok;
    logic [FAM_W-1:0] family_discrepancy;
  } result_t;

  // The CRC is linear in the code bits, so the CRC of the low seven bytes is
  // the XOR of one column per set bit. Bits of the top byte have no column.
  typedef logic [ROM_W-1:0][7:0] crc_col_t;

  function automatic crc_col_t crc_columns();
    crc_col_t   cols;
    logic [7:0] crc;
    logic       mix;
    cols = '0;
    for (int i = 0; i < CRC_BITS; i++) begin
      crc = '0;
      for (int k = i; k < CRC_BITS; k++) begin
        mix = crc[0] ^ ((k == i) ? 1'b1 : 1'b0);
        crc = crc >> 1;
        if (mix) begin
          crc = crc ^ CRC_POLY;
        end
      end
      cols[i] = crc;
    end
    return cols;
  endfunction

  localparam crc_col_t CRC_COLUMN = crc_columns();

  // Forget the discrepancy history and the last-device flag.
  function automatic state_t clear_counters(state_t s);
    state_t r;
    r          = s;
    r.last_disc = '0;
    r.last_fam  = '0;
    r.last_dev  = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

### src/onewire_rom_search.sv
// 1-Wire ROM search engine, decision logic only (bus timing lives elsewhere).
// Input stream: tuser carries the request kind (restart, begin pass, bit pair);
// tdata carries the presence result and the id/complement pair read from the
// bus. Every accepted request produces exactly one result on the output
// stream, in order: the search command strobe, the direction bit to write
// back, the pass outcome (tlast marks the end of a pass), the ROM code, its
// CRC-8 check and the family discrepancy position.
// A request passes the input register and then the result register, so its
// result is registered twice between the input port and the output port;
// throughput is one request per cycle while the receiver does not stall,
// set by the combinational state update between the two registers.
// Reset clears the search state (bit position back to one) and empties both
// registers. When the receiver stalls, the result waits in the output
// register and the input register still takes one more request; after that
// s_axis_tready_o drops until the result is taken.
`default_nettype none

module onewire_rom_search (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [0] presence, [1] id_bit, [2] complement_bit, [7:3] zero
  input  wire  [7:0]                       s_axis_tdata_i,
  // [1:0] kind
  input  wire  [1:0]                       s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  wire                              m_axis_tready_i,
  // [0] send_search_command, [1] write_valid, [2] direction_bit,
  // [3] device_found, [4] last_device, [68:5] rom_code, [69] crc_ok,
  // [73:70] family_discrepancy, [79:74] zero
  output logic [orsrch_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // pass_done
  output logic                             m_axis_tlast_o
);

  // Input register: holds one request until the state update can take it.
  logic                in_valid_q;
  orsrch_pkg::item_t   in_item_q;

  // Search state.
  orsrch_pkg::state_t  st_q;
  orsrch_pkg::state_t  st_d;

  // Result register.
  logic                out_valid_q;
  orsrch_pkg::result_t out_q;
  orsrch_pkg::result_t res_d;

  logic advance;
  logic in_ready;

  // A request moves into the result register whenever that register is free
  // or is being emptied in this same cycle.
  assign advance  = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign in_ready = !in_valid_q || advance;

  orsrch_step u_step (
    .st_i   (st_q),
    .item_i (in_item_q),
    .st_o   (st_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && s_axis_tvalid_i) begin
      in_item_q.kind           <= s_axis_tuser_i;
      in_item_q.presence       <= s_axis_tdata_i[0];
      in_item_q.id_bit         <= s_axis_tdata_i[1];
      in_item_q.complement_bit <= s_axis_tdata_i[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= orsrch_pkg::STATE_RESET;
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign s_axis_tready_o = in_ready;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_q.pass_done;
  assign m_axis_tdata_o  = {
    (orsrch_pkg::OUT_DATA_W - orsrch_pkg::OUT_FIELDS_W)'(0),
    out_q.family_discrepancy,
    out_q.crc_ok,
    out_q.rom_code,
    out_q.last_device,
    out_q.device_found,
    out_q.direction_bit,
    out_q.write_valid,
    out_q.send_search_command
  };

endmodule

`default_nettype wire

### src/orsrch_step.sv
`default_nettype none

// Next search state and result for one request.
module orsrch_step (
  input  var orsrch_pkg::state_t  st_i,
  input  var orsrch_pkg::item_t   item_i,
  output orsrch_pkg::state_t      st_o,
  output orsrch_pkg::result_t     res_o
);

  logic [orsrch_pkg::POS_W-1:0] pos_m1;
  logic [orsrch_pkg::POS_W-1:0] pos_next;
  logic [5:0]                   idx;
  logic                         cur_bit;
  logic                         is_tie;
  logic                         dir;
  orsrch_pkg::state_t           st_d;
  orsrch_pkg::result_t          res;

  assign pos_m1   = st_i.bit_pos - orsrch_pkg::POS_W'(1);
  assign pos_next = st_i.bit_pos + orsrch_pkg::POS_W'(1);
  assign idx      = pos_m1[5:0];
  assign cur_bit  = st_i.rom[idx];
  assign is_tie   = (item_i.id_bit == item_i.complement_bit);

  // On a discrepancy, follow the previous path below the last discrepancy,
  // take the one branch at it and the zero branch beyond it.
  always_comb begin
    if (!is_tie) begin
      dir = item_i.id_bit;
    end else if (st_i.bit_pos < st_i.last_disc) begin
      dir = cur_bit;
    end else begin
      dir = (st_i.bit_pos == st_i.last_disc);
    end
  end

  always_comb begin
    st_d = st_i;
    res  = '0;
    unique case (item_i.kind)
      orsrch_pkg::KIND_RESTART: begin
        st_d = orsrch_pkg::STATE_RESET;
      end
      orsrch_pkg::KIND_PASS: begin
        st_d.in_pass   = 1'b0;
        st_d.bit_pos   = orsrch_pkg::POS_W'(1);
        st_d.zero_pos  = '0;
        if (st_i.last_dev) begin
          st_d            = orsrch_pkg::clear_counters(st_d);
          res.pass_done   = 1'b1;
          res.last_device = 1'b1;
        end else if (!item_i.presence) begin
          st_d          = orsrch_pkg::clear_counters(st_d);
          res.pass_done = 1'b1;
        end else begin
          res.send_search_command = 1'b1;
          st_d.in_pass            = 1'b1;
        end
      end
      orsrch_pkg::KIND_PAIR: begin
        if (st_i.in_pass) begin
          if (item_i.id_bit && item_i.complement_bit) begin
            st_d          = orsrch_pkg::clear_counters(st_d);
            st_d.in_pass  = 1'b0;
            res.pass_done = 1'b1;
          end else begin
            if (is_tie && !dir) begin
              st_d.zero_pos = st_i.bit_pos;
              if (st_i.bit_pos < orsrch_pkg::FAMILY_LIMIT) begin
                st_d.last_fam = st_i.bit_pos[orsrch_pkg::FAM_W-1:0];
              end
            end
            st_d.rom[idx] = dir;
            if (dir != cur_bit) begin
              st_d.crc = st_i.crc ^ orsrch_pkg::CRC_COLUMN[idx];
            end
            res.write_valid   = 1'b1;
            res.direction_bit = dir;
            st_d.bit_pos      = pos_next;
            if (pos_next >= orsrch_pkg::END_POSITION) begin
              st_d.in_pass   = 1'b0;
              res.pass_done  = 1'b1;
              st_d.last_disc = st_d.zero_pos;
              if (st_d.zero_pos == '0) begin
                st_d.last_dev = 1'b1;
              end
              if (st_d.rom[7:0] == 8'h00) begin
                st_d = orsrch_pkg::clear_counters(st_d);
              end else begin
                res.device_found = 1'b1;
                res.last_device  = st_d.last_dev;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
    res.rom_code           = st_d.rom;
    res.crc_ok             = (st_d.crc == st_d.rom[orsrch_pkg::ROM_W-1 -: 8]);
    res.family_discrepancy = st_d.last_fam;
  end

  assign st_o  = st_d;
  assign res_o = res;

endmodule

`default_nettype wire

### src/orsrch_checker.sv
`default_nettype none

`include "assert_macros.svh"

// Port-level checks for the ROM search engine.
module orsrch_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              m_axis_tvalid_o,
  input wire                              m_axis_tready_i,
  input wire [orsrch_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire                              m_axis_tlast_o
);

  logic found;
  logic lastdev;
  logic send;
  logic wvalid;

  assign found   = m_axis_tdata_o[orsrch_pkg::OUT_FOUND_BIT];
  assign lastdev = m_axis_tdata_o[orsrch_pkg::OUT_LASTDEV_BIT];
  assign send    = m_axis_tdata_o[orsrch_pkg::OUT_SEND_BIT];
  assign wvalid  = m_axis_tdata_o[orsrch_pkg::OUT_WVALID_BIT];

  // Once reset has been seen at an edge, no result is offered at the next one.
  `ORS_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !m_axis_tvalid_o, "result valid during reset")

  // A stalled result stays offered.
  `ORS_ASSERT(a_hold_valid, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "dropped")

  // A found device or a last-device report only comes at the end of a pass,
  // and a found device comes with the write of bit 64.
  `ORS_ASSERT(a_found_end, m_axis_tvalid_o && found |-> m_axis_tlast_o && wvalid, "found mid pass")
  `ORS_ASSERT(a_last_end, m_axis_tvalid_o && lastdev |-> m_axis_tlast_o, "last device mid pass")

  // Starting a pass never writes a bit or ends the pass in the same result.
  `ORS_ASSERT(a_send_alone, m_axis_tvalid_o && send |-> !wvalid && !m_axis_tlast_o, "mixed send")

endmodule

bind onewire_rom_search orsrch_checker u_orsrch_checker (.*);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import orsrch_pkg::*;

  // Kind 3 has no meaning; the engine must treat it like a pair outside a pass.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned LIVE_TARGET = 900;

  // Copy of the engine's search state, kept by the predictor and the stimulus
  // generator alike.
  typedef struct packed {
    logic [ROM_W-1:0] rom;
    logic [POS_W-1:0] last_disc;
    logic [FAM_W-1:0] last_fam;
    logic             last_dev;
    logic             in_pass;
    logic [POS_W-1:0] bit_pos;
    logic [POS_W-1:0] zero_pos;
  } search_state_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [7:0]            s_axis_tdata_i  = '0;
  logic [1:0]            s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;

  onewire_rom_search DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Requests waiting to be driven, and results owed by the engine.
  item_t         pending_requests[$];
  result_t       due_results[$];

  // Predictor state, advanced once per accepted request.
  search_state_t search_state;
  // Generator state: runs ahead of the engine while the request list is built.
  search_state_t gen_state;
  result_t       gen_res;

  int unsigned live_items   = 0;
  int unsigned sessions     = 0;
  int unsigned failures     = 0;
  int unsigned checked      = 0;
  int unsigned found_count  = 0;
  int unsigned lastdev_count = 0;
  int unsigned early_ends   = 0;
  int unsigned cycle_count  = 0;
  int unsigned cycle_limit  = 0;

  logic        req_taken = 1'b0;
  item_t       next_req;
  item_t       taken_req;
  search_state_t step_next;
  result_t     step_res;
  result_t     got;
  int unsigned tx_gap   = 0;
  int unsigned rx_stall = 0;
  logic        tx_calm  = 1'b0;
  logic        rx_calm  = 1'b0;

  function automatic search_state_t search_reset();
    search_state_t s;
    s         = '0;
    s.bit_pos = POS_W'(1);
    return s;
  endfunction

  // Dallas CRC-8, reflected, shifted in LSB first over bytes 0..6.
  function automatic logic [7:0] crc8_low7(input logic [ROM_W-1:0] code);
    logic [7:0] crc;
    logic       mix;
    crc = '0;
    for (int i = 0; i < CRC_BITS; i++) begin
      mix = crc[0] ^ code[i];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  function automatic search_state_t forget_history(input search_state_t s);
    search_state_t r;
    r           = s;
    r.last_disc = '0;
    r.last_fam  = '0;
    r.last_dev  = 1'b0;
    return r;
  endfunction

  // One request through the search algorithm: next state and the one result.
  function automatic void search_step(input search_state_t cur, input item_t req,
                                      output search_state_t nxt, output result_t res);
    logic [7:0] pos;
    logic [5:0] idx;
    logic       dir;
    nxt = cur;
    res = '0;
    pos = 8'(cur.bit_pos);
    idx = 6'(cur.bit_pos - POS_W'(1));
    dir = 1'b0;
    if (req.kind == KIND_RESTART) begin
      nxt = search_reset();
    end else if (req.kind == KIND_PASS) begin
      nxt.in_pass   = 1'b0;
      nxt.bit_pos   = POS_W'(1);
      nxt.zero_pos  = '0;
      if (cur.last_dev) begin
        // The previous pass found the last device: nothing left to search.
        nxt = forget_history(nxt);
        res.pass_done   = 1'b1;
        res.last_device = 1'b1;
      end else if (!req.presence) begin
        nxt = forget_history(nxt);
        res.pass_done = 1'b1;
      end else begin
        res.send_search_command = 1'b1;
        nxt.in_pass = 1'b1;
      end
    end else if (req.kind == KIND_PAIR && cur.in_pass) begin
      if (req.id_bit && req.complement_bit) begin
        // Nobody answered this bit: the pass is lost.
        nxt = forget_history(nxt);
        nxt.in_pass   = 1'b0;
        res.pass_done = 1'b1;
      end else begin
        if (req.id_bit != req.complement_bit) begin
          dir = req.id_bit;
        end else begin
          // Discrepancy: repeat the old path below the last discrepancy,
          // take the one branch at it and the zero branch beyond it.
          if (pos < 8'(cur.last_disc)) begin
            dir = cur.rom[idx];
          end else begin
            dir = (pos == 8'(cur.last_disc));
          end
          if (!dir) begin
            nxt.zero_pos = pos[POS_W-1:0];
            if (pos < 8'(FAMILY_LIMIT)) begin
              nxt.last_fam = pos[FAM_W-1:0];
            end
          end
        end
        nxt.rom[idx]      = dir;
        res.write_valid   = 1'b1;
        res.direction_bit = dir;
        pos               = pos + 8'd1;
        nxt.bit_pos       = pos[POS_W-1:0];
        if (pos >= 8'(END_POSITION)) begin
          nxt.in_pass   = 1'b0;
          res.pass_done = 1'b1;
          nxt.last_disc = nxt.zero_pos;
          if (nxt.last_disc == '0) begin
            nxt.last_dev = 1'b1;
          end
          if (nxt.rom[7:0] == 8'h00) begin
            nxt = forget_history(nxt);
          end else begin
            res.device_found = 1'b1;
            res.last_device  = nxt.last_dev;
          end
        end
      end
    end
    res.rom_code           = nxt.rom;
    res.crc_ok             = (crc8_low7(nxt.rom) == nxt.rom[63:56]);
    res.family_discrepancy = nxt.last_fam;
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  // Idle length between requests or between receiver ready cycles: mostly
  // none, some short, a few long. Calm stretches have no idling at all.
  function automatic int unsigned pick_gap(input logic calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Appends one request and runs it through the generator's own state, so
  // that the bus model knows which direction the engine will take.
  task automatic queue_request(input logic [1:0] kind, input logic presence,
                               input logic id_bit, input logic complement_bit);
    item_t         req;
    search_state_t nxt;
    req.kind           = kind;
    req.presence       = presence;
    req.id_bit         = id_bit;
    req.complement_bit = complement_bit;
    if (!(kind == KIND_UNUSED || (kind == KIND_PAIR && !gen_state.in_pass))) begin
      live_items++;
    end
    search_step(gen_state, req, nxt, gen_res);
    gen_state = nxt;
    pending_requests.push_back(req);
  endtask

  // A bus with a random set of devices that share most of their ROM bits, so
  // the search branches often, also inside the family byte. Now and then a
  // pair is corrupted, an unused kind slips in, or a pass is abandoned.
  task automatic search_population();
    logic [ROM_W-1:0] devs[$];
    logic [ROM_W-1:0] alive[$];
    logic [ROM_W-1:0] survivors[$];
    logic [ROM_W-1:0] base;
    logic [ROM_W-1:0] code;
    int unsigned      n_dev;
    int unsigned      cap;
    int unsigned      r;
    int unsigned      flip;
    logic             id_bit;
    logic             cmp_bit;
    logic             presence;
    logic             good_crc;
    logic             dup;
    n_dev = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
    base  = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) begin
      base[7:0] = 8'h00;
    end
    good_crc = ($urandom_range(0, 4) != 0);
    for (int d = 0; d < n_dev; d++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        code = '0;
      end else if (r == 1) begin
        code = '1;
      end else begin
        code = base;
        for (int f = $urandom_range(1, 3); f > 0; f--) begin
          flip = $urandom_range(0, CRC_BITS - 1);
          code[flip] = ~code[flip];
        end
        if ($urandom_range(0, 2) == 0) begin
          flip = $urandom_range(0, 7);
          code[flip] = ~code[flip];
        end
        if (good_crc) begin
          code[63:56] = crc8_low7(code);
        end
      end
      dup = 1'b0;
      foreach (devs[k]) begin
        if (devs[k] == code) begin
          dup = 1'b1;
        end
      end
      if (!dup) begin
        devs.push_back(code);
      end
    end

    if ($urandom_range(0, 9) < 7) begin
      queue_request(KIND_RESTART, coin(), coin(), coin());
    end
    cap = devs.size() + 3;
    for (int p = 0; p < cap; p++) begin
      presence = (devs.size() > 0);
      if ($urandom_range(0, 29) == 0) begin
        presence = ~presence;
      end
      queue_request(KIND_PASS, presence, coin(), coin());
      if (gen_res.pass_done) begin
        if (gen_res.last_device) begin
          break;
        end
        continue;
      end
      alive = devs;
      for (int b = 0; b < ROM_W; b++) begin
        r = $urandom_range(0, 199);
        if (r == 0) begin
          queue_request(KIND_UNUSED, coin(), coin(), coin());
        end else if (r == 1) begin
          // Abandon the pass; the next begin-pass request lands mid-pass.
          break;
        end
        // Wired-AND of the bit and of its complement over the survivors.
        id_bit  = 1'b1;
        cmp_bit = 1'b1;
        foreach (alive[k]) begin
          id_bit  = id_bit & alive[k][b];
          cmp_bit = cmp_bit & ~alive[k][b];
        end
        if ($urandom_range(0, 99) < 2) begin
          id_bit  = coin();
          cmp_bit = coin();
        end
        queue_request(KIND_PAIR, coin(), id_bit, cmp_bit);
        if (!gen_state.in_pass) begin
          break;
        end
        survivors = {};
        foreach (alive[k]) begin
          if (alive[k][b] == gen_res.direction_bit) begin
            survivors.push_back(alive[k]);
          end
        end
        alive = survivors;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [ROM_W-1:0] want,
                             input logic [ROM_W-1:0] actual);
    if (actual !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, actual);
      failures++;
    end
  endtask

  // Driver: presents the next request at the falling edge once the previous
  // one has been accepted, after a random gap. The receiver side stalls the
  // result stream in the same manner.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid_i || req_taken) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          next_req = pending_requests.pop_front();
          s_axis_tuser_i  <= next_req.kind;
          s_axis_tdata_i  <= {5'b0, next_req.complement_bit, next_req.id_bit,
                              next_req.presence};
          s_axis_tvalid_i <= 1'b1;
          if ($urandom_range(0, 99) == 0) begin
            tx_calm = ~tx_calm;
          end
          tx_gap = pick_gap(tx_calm);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        if ($urandom_range(0, 99) == 0) begin
          rx_calm = ~rx_calm;
        end
        if ($urandom_range(0, 3) == 0) begin
          rx_stall = pick_gap(rx_calm);
        end
      end
    end
  end

  // Monitor: at each rising edge, compare a delivered result with the oldest
  // one owed, then predict the result of a request accepted at this edge.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= cycle_limit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, due_results.size());
      $display("Test completed with failures");
      $finish;
    end
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.send_search_command = m_axis_tdata_o[OUT_SEND_BIT];
        got.write_valid         = m_axis_tdata_o[OUT_WVALID_BIT];
        got.direction_bit       = m_axis_tdata_o[OUT_DIR_BIT];
        got.device_found        = m_axis_tdata_o[OUT_FOUND_BIT];
        got.last_device         = m_axis_tdata_o[OUT_LASTDEV_BIT];
        got.rom_code            = m_axis_tdata_o[OUT_LASTDEV_BIT + 1 +: ROM_W];
        got.crc_ok              = m_axis_tdata_o[OUT_LASTDEV_BIT + 1 + ROM_W];
        got.family_discrepancy  = m_axis_tdata_o[OUT_LASTDEV_BIT + 2 + ROM_W +: FAM_W];
        got.pass_done           = m_axis_tlast_o;
        if (due_results.size() == 0) begin
          $error("result delivered with no request outstanding: tdata 0x%0h",
                 m_axis_tdata_o);
          failures++;
        end else begin
          step_res = due_results.pop_front();
          checked++;
          if (step_res.device_found) found_count++;
          if (step_res.last_device) lastdev_count++;
          if (step_res.pass_done && !step_res.device_found && !step_res.last_device) begin
            early_ends++;
          end
          check_field("send_search_command", step_res.send_search_command,
                      got.send_search_command);
          check_field("write_valid", step_res.write_valid, got.write_valid);
          check_field("direction_bit", step_res.direction_bit, got.direction_bit);
          check_field("pass_done", step_res.pass_done, got.pass_done);
          check_field("device_found", step_res.device_found, got.device_found);
          check_field("last_device", step_res.last_device, got.last_device);
          check_field("rom_code", step_res.rom_code, got.rom_code);
          check_field("crc_ok", step_res.crc_ok, got.crc_ok);
          check_field("family_discrepancy", step_res.family_discrepancy,
                      got.family_discrepancy);
        end
      end
      req_taken <= s_axis_tvalid_i && s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        taken_req.kind           = s_axis_tuser_i;
        taken_req.presence       = s_axis_tdata_i[0];
        taken_req.id_bit         = s_axis_tdata_i[1];
        taken_req.complement_bit = s_axis_tdata_i[2];
        search_step(search_state, taken_req, step_next, step_res);
        search_state = step_next;
        due_results.push_back(step_res);
      end
    end
  end

  initial begin
    int unsigned directed_live;
    search_state = search_reset();
    gen_state    = search_reset();
    cycle_limit  = 1000000;

    // Directed cases first: a pair before any pass, the unused kind with all
    // fields high, a pass with no presence, the three kinds of pair, the
    // unused kind inside a pass, a pass restarted mid-way, a both-ones abort
    // followed by a stray pair, and a restart followed by another both-ones abort.
    queue_request(KIND_PAIR, 1'b0, 1'b1, 1'b0);
    queue_request(KIND_UNUSED, 1'b1, 1'b1, 1'b1);
    queue_request(KIND_PASS, 1'b0, 1'b1, 1'b1);
    queue_request(KIND_PASS, 1'b1, 1'b0, 1'b0);
    queue_request(KIND_PAIR, 1'b0, 1'b0, 1'b1);
    queue_request(KIND_PAIR, 1'b1, 1'b1, 1'b0);
    queue_request(KIND_PAIR, 1'b0, 1'b0, 1'b0);
    queue_request(KIND_UNUSED, 1'b0, 1'b0, 1'b0);
    queue_request(KIND_PASS, 1'b1, 1'b1, 1'b1);
    queue_request(KIND_PAIR, 1'b1, 1'b0, 1'b0);
    queue_request(KIND_PAIR, 1'b0, 1'b1, 1'b1);
    queue_request(KIND_PAIR, 1'b1, 1'b0, 1'b0);
    queue_request(KIND_RESTART, 1'b1, 1'b1, 1'b1);
    queue_request(KIND_PASS, 1'b1, 1'b0, 1'b1);
    queue_request(KIND_PAIR, 1'b0, 1'b1, 1'b1);

    // Random part: mostly complete searches over random device sets, with
    // a burst of unstructured requests now and then.
    directed_live = live_items;
    while (live_items - directed_live < LIVE_TARGET) begin
      sessions++;
      if ($urandom_range(0, 6) == 0) begin
        for (int j = 0; j < 20; j++) begin
          queue_request(2'($urandom_range(0, 3)), coin(), coin(), coin());
        end
      end
      search_population();
    end

    // Worst case per request: a long sender gap, a long receiver stall and
    // the passage through both registers; taken several times over.
    cycle_limit = pending_requests.size() * 300 + 5000;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_requests.size() != 0 || s_axis_tvalid_i) @(negedge clk_i);
    while (due_results.size() != 0) @(negedge clk_i);
    // Leave room for any result the engine should not have produced.
    repeat (10) @(negedge clk_i);

    $display("Checked %0d results over %0d search sessions plus directed cases.",
             checked, sessions);
    $display("Devices found %0d, last-device reports %0d, passes ended early %0d.",
             found_count, lastdev_count, early_ends);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
